FILE: rtl/rs485_buffered_uart_front_defines.svh
// Assertion macros shared by the checker files of the UART front end.
`ifndef RS485_BUFFERED_UART_FRONT_DEFINES_SVH
`define RS485_BUFFERED_UART_FRONT_DEFINES_SVH

// Property checked on every rising clock edge outside of reset.
`define RS485UF_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define RS485UF_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/rs485uf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485uf_pkg
// Types and constants of the buffered RS485 UART front end.
// ----------------------------------------------------------------------------
package rs485uf_pkg;

  localparam int RxDepth = 64;
  localparam int TxDepth = 64;
  localparam int RxPtrW  = $clog2(RxDepth);
  localparam int TxPtrW  = $clog2(TxDepth);
  localparam logic [RxPtrW-1:0] RxLast = RxPtrW'(RxDepth - 1);
  localparam logic [TxPtrW-1:0] TxLast = TxPtrW'(TxDepth - 1);

  localparam int ByteW  = 8;
  localparam int FillW  = 6;
  localparam int ModeW  = 3;
  localparam int CfgW   = 4;
  localparam logic [CfgW-1:0] DataBitsReset = 4'd8;

  typedef enum logic [ModeW-1:0] {
    MODE_RX_BYTE    = 3'd0,
    MODE_HOST_READ  = 3'd1,
    MODE_HOST_WRITE = 3'd2,
    MODE_TX_READY   = 3'd3,
    MODE_TX_DONE    = 3'd4
  } mode_e;

  // One result as held in the result register; the two ring bytes come
  // from the RAM read registers and are selected by the two flags.
  typedef struct packed {
    logic             status;
    logic             rd_sel;
    logic             line_sel;
    logic             drive_enable;
    logic             ready_request;
    logic [FillW-1:0] rx_fill;
    logic [FillW-1:0] tx_fill;
    logic             rx_overrun;
    logic             tx_overrun;
  } result_t;

endpackage

FILE: rtl/rs485uf_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485uf_in_if
// Event request channel: mode and data byte with valid/ready.
// ----------------------------------------------------------------------------
interface rs485uf_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [7:0] data_byte;

  modport source (output valid, output mode, output data_byte, input ready);
  modport sink   (input valid, input mode, input data_byte, output ready);
  modport monitor (input valid, input ready, input mode, input data_byte);
endinterface

FILE: rtl/rs485uf_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485uf_out_if
// Result channel: one result per request with valid/ready.
// ----------------------------------------------------------------------------
interface rs485uf_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [7:0] read_data;
  logic       line_valid;
  logic [7:0] line_byte;
  logic       drive_enable;
  logic       ready_request;
  logic [5:0] rx_fill;
  logic [5:0] tx_fill;
  logic       rx_overrun;
  logic       tx_overrun;

  modport source (output valid, output status, output read_data, output line_valid,
                  output line_byte, output drive_enable, output ready_request,
                  output rx_fill, output tx_fill, output rx_overrun,
                  output tx_overrun, input ready);
  modport sink   (input valid, input status, input read_data, input line_valid,
                  input line_byte, input drive_enable, input ready_request,
                  input rx_fill, input tx_fill, input rx_overrun,
                  input tx_overrun, output ready);
  modport monitor (input valid, input ready, input status, input read_data,
                   input line_valid, input line_byte, input drive_enable,
                   input ready_request, input rx_fill, input tx_fill,
                   input rx_overrun, input tx_overrun);
endinterface

FILE: rtl/rs485uf_cfg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485uf_cfg_if
// Configuration write channel carrying the character width.
// ----------------------------------------------------------------------------
interface rs485uf_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] data_bits;

  modport source (output valid, output data_bits, input ready);
  modport sink   (input valid, input data_bits, output ready);
  modport monitor (input valid, input ready, input data_bits);
endinterface

FILE: rtl/rs485_buffered_uart_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485_buffered_uart_front
// Receive and transmit byte rings with direction control for an RS485 UART.
// ----------------------------------------------------------------------------
//   channel  dir  handshake     carries
//   req_i    in   valid/ready   mode, data_byte
//   rsp_o    out  valid/ready   status, read_data, line and ring status
//   cfg_i    in   valid/ready   data_bits
//
// One request per cycle sustained while results are taken; a result is
// offered once its request has passed the request register and the result
// register (the request register feeds the ring logic, which loads the result
// register and the ring RAM read register). Reset clears pointers, levels and
// flags at once; the ring RAMs need no clearing. A stalled result holds the
// request register, which then holds off req_i.
module rs485_buffered_uart_front
  import rs485uf_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  rs485uf_in_if.sink   req_i,
  rs485uf_out_if.source rsp_o,
  rs485uf_cfg_if.sink  cfg_i
);

  logic              item_valid_q;
  logic [ModeW-1:0]  mode_q;
  logic [ByteW-1:0]  byte_q;
  logic [CfgW-1:0]   data_bits_q;
  logic              advance;
  logic              res_valid;
  result_t           res;
  logic              rx_we, rx_re, tx_we, tx_re;
  logic [RxPtrW-1:0] rx_waddr, rx_raddr;
  logic [TxPtrW-1:0] tx_waddr, tx_raddr;
  logic [ByteW-1:0]  rx_wdata, tx_wdata, rx_rdata, tx_rdata;

  assign cfg_i.ready = 1'b1;
  assign req_i.ready = !item_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q  <= DataBitsReset;
      item_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        data_bits_q <= cfg_i.data_bits;
      end
      if (req_i.ready) begin
        item_valid_q <= req_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      mode_q <= req_i.mode;
      byte_q <= req_i.data_byte;
    end
  end

  rs485uf_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid_q),
    .mode_i       (mode_q),
    .data_byte_i  (byte_q),
    .data_bits_i  (data_bits_q),
    .res_ready_i  (rsp_o.ready),
    .advance_o    (advance),
    .res_valid_o  (res_valid),
    .res_o        (res),
    .rx_we_o      (rx_we),
    .rx_waddr_o   (rx_waddr),
    .rx_wdata_o   (rx_wdata),
    .rx_re_o      (rx_re),
    .rx_raddr_o   (rx_raddr),
    .tx_we_o      (tx_we),
    .tx_waddr_o   (tx_waddr),
    .tx_wdata_o   (tx_wdata),
    .tx_re_o      (tx_re),
    .tx_raddr_o   (tx_raddr)
  );

  rs485uf_ram #(.Depth(RxDepth), .Width(ByteW)) u_rx_ram (
    .clk_i   (clk_i),
    .we_i    (rx_we),
    .waddr_i (rx_waddr),
    .wdata_i (rx_wdata),
    .re_i    (rx_re),
    .raddr_i (rx_raddr),
    .rdata_o (rx_rdata)
  );

  rs485uf_ram #(.Depth(TxDepth), .Width(ByteW)) u_tx_ram (
    .clk_i   (clk_i),
    .we_i    (tx_we),
    .waddr_i (tx_waddr),
    .wdata_i (tx_wdata),
    .re_i    (tx_re),
    .raddr_i (tx_raddr),
    .rdata_o (tx_rdata)
  );

  assign rsp_o.valid         = res_valid;
  assign rsp_o.status        = res.status;
  assign rsp_o.read_data     = res.rd_sel ? rx_rdata : '0;
  assign rsp_o.line_valid    = res.line_sel;
  assign rsp_o.line_byte     = res.line_sel ? tx_rdata : '0;
  assign rsp_o.drive_enable  = res.drive_enable;
  assign rsp_o.ready_request = res.ready_request;
  assign rsp_o.rx_fill       = res.rx_fill;
  assign rsp_o.tx_fill       = res.tx_fill;
  assign rsp_o.rx_overrun    = res.rx_overrun;
  assign rsp_o.tx_overrun    = res.tx_overrun;

endmodule

FILE: rtl/rs485uf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485uf_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rs485uf_ram #(
  parameter int Depth = 64,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/rs485uf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485uf_ctrl
// Ring pointers, levels, flags and direction control; builds one result.
// ----------------------------------------------------------------------------
module rs485uf_ctrl
  import rs485uf_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  logic [ModeW-1:0]  mode_i,
  input  logic [ByteW-1:0]  data_byte_i,
  input  logic [CfgW-1:0]   data_bits_i,
  input  logic              res_ready_i,
  output logic              advance_o,
  output logic              res_valid_o,
  output result_t           res_o,
  output logic              rx_we_o,
  output logic [RxPtrW-1:0] rx_waddr_o,
  output logic [ByteW-1:0]  rx_wdata_o,
  output logic              rx_re_o,
  output logic [RxPtrW-1:0] rx_raddr_o,
  output logic              tx_we_o,
  output logic [TxPtrW-1:0] tx_waddr_o,
  output logic [ByteW-1:0]  tx_wdata_o,
  output logic              tx_re_o,
  output logic [TxPtrW-1:0] tx_raddr_o
);

  logic [RxPtrW-1:0] rx_wr_q, rx_wr_d, rx_rd_q, rx_rd_d, rx_lvl_q, rx_lvl_d;
  logic [TxPtrW-1:0] tx_wr_q, tx_wr_d, tx_rd_q, tx_rd_d, tx_lvl_q, tx_lvl_d;
  logic              rx_lost_q, rx_lost_d, tx_lost_q, tx_lost_d;
  logic              drained_q, drained_d, dir_q, dir_d, req_q, req_d;
  logic              res_valid_q, res_valid_d;
  result_t           res_q, res_d;
  logic [RxPtrW-1:0] rx_wr_nxt, rx_rd_nxt;
  logic [TxPtrW-1:0] tx_wr_nxt, tx_rd_nxt;
  logic [ByteW-1:0]  char_mask;
  logic              status, rd_sel, line_sel;

  // Widths below five act as five, widths above eight as eight.
  always_comb begin
    unique case (data_bits_i) inside
      [4'd0:4'd5]: char_mask = 8'h1f;
      4'd6:        char_mask = 8'h3f;
      4'd7:        char_mask = 8'h7f;
      default:     char_mask = 8'hff;
    endcase
  end

  assign rx_wr_nxt = (rx_wr_q == RxLast) ? '0 : rx_wr_q + 1'b1;
  assign rx_rd_nxt = (rx_rd_q == RxLast) ? '0 : rx_rd_q + 1'b1;
  assign tx_wr_nxt = (tx_wr_q == TxLast) ? '0 : tx_wr_q + 1'b1;
  assign tx_rd_nxt = (tx_rd_q == TxLast) ? '0 : tx_rd_q + 1'b1;

  assign advance_o = item_valid_i && (!res_valid_q || res_ready_i);

  assign rx_waddr_o = rx_wr_nxt;
  assign rx_wdata_o = data_byte_i & char_mask;
  assign rx_raddr_o = rx_rd_nxt;
  assign tx_waddr_o = tx_wr_nxt;
  assign tx_wdata_o = data_byte_i;
  assign tx_raddr_o = tx_rd_nxt;

  always_comb begin
    rx_wr_d   = rx_wr_q;
    rx_rd_d   = rx_rd_q;
    rx_lvl_d  = rx_lvl_q;
    tx_wr_d   = tx_wr_q;
    tx_rd_d   = tx_rd_q;
    tx_lvl_d  = tx_lvl_q;
    rx_lost_d = rx_lost_q;
    tx_lost_d = tx_lost_q;
    drained_d = drained_q;
    dir_d     = dir_q;
    req_d     = req_q;
    status    = 1'b0;
    rd_sel    = 1'b0;
    line_sel  = 1'b0;
    rx_we_o   = 1'b0;
    rx_re_o   = 1'b0;
    tx_we_o   = 1'b0;
    tx_re_o   = 1'b0;
    if (advance_o) begin
      unique case (mode_e'(mode_i))
        MODE_RX_BYTE: begin
          if (rx_wr_nxt == rx_rd_q) begin
            rx_lost_d = 1'b1;
          end else begin
            rx_lost_d = 1'b0;
            rx_wr_d   = rx_wr_nxt;
            rx_we_o   = 1'b1;
            rx_lvl_d  = rx_lvl_q + 1'b1;
          end
        end
        MODE_HOST_READ: begin
          if (rx_wr_q == rx_rd_q) begin
            rx_lvl_d = '0;
          end else begin
            rx_rd_d = rx_rd_nxt;
            rx_re_o = 1'b1;
            rd_sel  = 1'b1;
            status  = 1'b1;
            if (rx_lvl_q != '0) begin
              rx_lvl_d = rx_lvl_q - 1'b1;
            end
          end
        end
        MODE_HOST_WRITE: begin
          if (tx_wr_nxt == tx_rd_q) begin
            tx_lost_d = 1'b1;
          end else begin
            dir_d    = 1'b1;
            req_d    = 1'b1;
            tx_wr_d  = tx_wr_nxt;
            tx_we_o  = 1'b1;
            tx_lvl_d = tx_lvl_q + 1'b1;
            status   = 1'b1;
          end
        end
        MODE_TX_READY: begin
          if (req_q) begin
            if (tx_wr_q != tx_rd_q) begin
              tx_rd_d  = tx_rd_nxt;
              tx_re_o  = 1'b1;
              line_sel = 1'b1;
              if (tx_lvl_q != '0) begin
                tx_lvl_d = tx_lvl_q - 1'b1;
              end
            end else begin
              req_d     = 1'b0;
              drained_d = 1'b1;
              tx_lvl_d  = '0;
            end
          end
        end
        MODE_TX_DONE: begin
          if (drained_q) begin
            dir_d     = 1'b0;
            drained_d = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (advance_o) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
    res_d               = res_q;
    res_d.status        = status;
    res_d.rd_sel        = rd_sel;
    res_d.line_sel      = line_sel;
    res_d.drive_enable  = dir_d;
    res_d.ready_request = req_d;
    res_d.rx_fill       = FillW'(rx_lvl_d);
    res_d.tx_fill       = FillW'(tx_lvl_d);
    res_d.rx_overrun    = rx_lost_d;
    res_d.tx_overrun    = tx_lost_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_wr_q     <= '0;
      rx_rd_q     <= '0;
      rx_lvl_q    <= '0;
      tx_wr_q     <= '0;
      tx_rd_q     <= '0;
      tx_lvl_q    <= '0;
      rx_lost_q   <= 1'b0;
      tx_lost_q   <= 1'b0;
      drained_q   <= 1'b0;
      dir_q       <= 1'b0;
      req_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      rx_wr_q     <= rx_wr_d;
      rx_rd_q     <= rx_rd_d;
      rx_lvl_q    <= rx_lvl_d;
      tx_wr_q     <= tx_wr_d;
      tx_rd_q     <= tx_rd_d;
      tx_lvl_q    <= tx_lvl_d;
      rx_lost_q   <= rx_lost_d;
      tx_lost_q   <= tx_lost_d;
      drained_q   <= drained_d;
      dir_q       <= dir_d;
      req_q       <= req_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/rs485uf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485uf_checker
// Port-level checks of the UART front end, bound to the top level.
// ----------------------------------------------------------------------------
`include "rs485_buffered_uart_front_defines.svh"

module rs485uf_checker (
  input logic           clk_i,
  input logic           rst_ni,
  rs485uf_in_if.sink    req_i,
  rs485uf_out_if.source rsp_o,
  rs485uf_cfg_if.sink   cfg_i
);

  // A stalled result must stay valid and keep its status, read data, line byte and tx fill.
  `RS485UF_ASSERT(a_rsp_hold, clk_i, rst_ni,
                  rsp_o.valid && !rsp_o.ready |=> rsp_o.valid && $stable(rsp_o.status) &&
                  $stable(rsp_o.read_data) && $stable(rsp_o.line_byte) &&
                  $stable(rsp_o.tx_fill),
                  "stalled result changed")

  // A byte only goes to the line while transmitter-ready events are wanted.
  `RS485UF_ASSERT(a_line_req, clk_i, rst_ni,
                  rsp_o.valid && rsp_o.line_valid |-> rsp_o.ready_request,
                  "line byte without ready request")

  // A host access and a line handoff never share one result.
  `RS485UF_ASSERT(a_excl, clk_i, rst_ni,
                  rsp_o.valid && rsp_o.line_valid |-> !rsp_o.status && rsp_o.read_data == 8'h00,
                  "line byte together with host access")

  // Read data is zero unless a host read succeeded.
  `RS485UF_ASSERT(a_rdata, clk_i, rst_ni,
                  rsp_o.valid && rsp_o.read_data != 8'h00 |-> rsp_o.status,
                  "read data without successful read")

  // No result is offered during reset.
  `RS485UF_ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |-> !rsp_o.valid, "result valid in reset")

endmodule

bind rs485_buffered_uart_front rs485uf_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .req_i  (req_i),
  .rsp_o  (rsp_o),
  .cfg_i  (cfg_i)
);

FILE: tb/sv/rs485uf_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485uf_result_checker
// Watches the request, result and width channels of the UART front end,
// keeps its own copy of both rings, pointers and flags, and compares every
// result with the one predicted for the oldest open request.
// ----------------------------------------------------------------------------
module rs485uf_result_checker
  import rs485uf_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  rs485uf_in_if.monitor  req_i,
  rs485uf_out_if.monitor rsp_i,
  rs485uf_cfg_if.monitor cfg_i,
  output int            failures_o,
  output int            results_due_o,
  output int            checked_o
);

  typedef struct packed {
    logic             status;
    logic [ByteW-1:0] read_data;
    logic             line_valid;
    logic [ByteW-1:0] line_byte;
    logic             drive_enable;
    logic             ready_request;
    logic [FillW-1:0] rx_fill;
    logic [FillW-1:0] tx_fill;
    logic             rx_overrun;
    logic             tx_overrun;
  } uart_result_t;

  logic [ByteW-1:0]  rx_mem [RxDepth];
  logic [ByteW-1:0]  tx_mem [TxDepth];
  logic [RxPtrW-1:0] rx_head, rx_tail;
  logic [TxPtrW-1:0] tx_head, tx_tail;
  int                rx_level, tx_level;
  logic              rx_lost, tx_lost, tx_drained, drive_tx, want_ready;
  logic [CfgW-1:0]   char_bits;

  uart_result_t      pending_results [$];
  int                mismatches = 0;
  int                checked = 0;

  function automatic logic [RxPtrW-1:0] next_rx(logic [RxPtrW-1:0] p);
    return (p == RxLast) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [TxPtrW-1:0] next_tx(logic [TxPtrW-1:0] p);
    return (p == TxLast) ? '0 : p + 1'b1;
  endfunction

  // Widths below five act as five and widths above eight act as eight.
  function automatic logic [ByteW-1:0] char_mask();
    int b;
    b = char_bits;
    if (b < 5) b = 5;
    if (b > 8) b = 8;
    return ByteW'((1 << b) - 1);
  endfunction

  function automatic uart_result_t apply_event(logic [ModeW-1:0] m, logic [ByteW-1:0] b);
    uart_result_t      r;
    logic [RxPtrW-1:0] rn;
    logic [TxPtrW-1:0] tn;
    r = '0;
    case (m)
      MODE_RX_BYTE: begin
        rn = next_rx(rx_head);
        if (rn == rx_tail) begin
          rx_lost = 1'b1;
        end else begin
          rx_lost    = 1'b0;
          rx_head    = rn;
          rx_mem[rn] = b & char_mask();
          rx_level++;
        end
      end
      MODE_HOST_READ: begin
        if (rx_head == rx_tail) begin
          rx_level = 0;
        end else begin
          rn          = next_rx(rx_tail);
          rx_tail     = rn;
          r.read_data = rx_mem[rn];
          if (rx_level > 0) rx_level--;
          r.status    = 1'b1;
        end
      end
      MODE_HOST_WRITE: begin
        tn = next_tx(tx_head);
        if (tn == tx_tail) begin
          tx_lost = 1'b1;
        end else begin
          drive_tx   = 1'b1;
          tx_mem[tn] = b;
          tx_head    = tn;
          want_ready = 1'b1;
          tx_level++;
          r.status   = 1'b1;
        end
      end
      MODE_TX_READY: begin
        // A transmitter-ready event that was not requested changes nothing.
        if (want_ready) begin
          if (tx_head != tx_tail) begin
            tn           = next_tx(tx_tail);
            tx_tail      = tn;
            r.line_valid = 1'b1;
            r.line_byte  = tx_mem[tn];
            if (tx_level > 0) tx_level--;
          end else begin
            want_ready = 1'b0;
            tx_drained = 1'b1;
            tx_level   = 0;
          end
        end
      end
      MODE_TX_DONE: begin
        if (tx_drained) begin
          drive_tx   = 1'b0;
          tx_drained = 1'b0;
        end
      end
      default: begin
      end
    endcase
    r.drive_enable  = drive_tx;
    r.ready_request = want_ready;
    r.rx_fill       = FillW'(rx_level);
    r.tx_fill       = FillW'(tx_level);
    r.rx_overrun    = rx_lost;
    r.tx_overrun    = tx_lost;
    return r;
  endfunction

  function automatic void check_field(string name, logic [ByteW-1:0] want,
                                      logic [ByteW-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    uart_result_t want;
    if (!rst_ni) begin
      rx_head    = '0;
      rx_tail    = '0;
      tx_head    = '0;
      tx_tail    = '0;
      rx_level   = 0;
      tx_level   = 0;
      rx_lost    = 1'b0;
      tx_lost    = 1'b0;
      tx_drained = 1'b0;
      drive_tx   = 1'b0;
      want_ready = 1'b0;
      char_bits  = DataBitsReset;
      pending_results.delete();
    end else begin
      if (cfg_i.valid && cfg_i.ready) char_bits = cfg_i.data_bits;
      if (rsp_i.valid && rsp_i.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no open request, expected none, got status %b rx_fill %0d",
                   $time, rsp_i.status, rsp_i.rx_fill);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", ByteW'(want.status), ByteW'(rsp_i.status));
          check_field("read_data", want.read_data, rsp_i.read_data);
          check_field("line_valid", ByteW'(want.line_valid), ByteW'(rsp_i.line_valid));
          check_field("line_byte", want.line_byte, rsp_i.line_byte);
          check_field("drive_enable", ByteW'(want.drive_enable),
                      ByteW'(rsp_i.drive_enable));
          check_field("ready_request", ByteW'(want.ready_request),
                      ByteW'(rsp_i.ready_request));
          check_field("rx_fill", ByteW'(want.rx_fill), ByteW'(rsp_i.rx_fill));
          check_field("tx_fill", ByteW'(want.tx_fill), ByteW'(rsp_i.tx_fill));
          check_field("rx_overrun", ByteW'(want.rx_overrun), ByteW'(rsp_i.rx_overrun));
          check_field("tx_overrun", ByteW'(want.tx_overrun), ByteW'(rsp_i.tx_overrun));
          checked++;
        end
      end
      if (req_i.valid && req_i.ready) begin
        pending_results.push_back(apply_event(req_i.mode, req_i.data_byte));
      end
    end
    failures_o    <= mismatches;
    results_due_o <= pending_results.size();
    checked_o     <= checked;
  end

endmodule

FILE: tb/sv/rs485_buffered_uart_front_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rs485_buffered_uart_front_tb
// Drives receive, host and transmitter events into the UART front end with
// random gaps and result stalls in all but the last phase, steps the
// character width between traffic phases, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module rs485_buffered_uart_front_tb;
  import rs485uf_pkg::*;

  localparam int QuietLimit  = 2000;
  localparam int DrainCycles = 8;
  localparam logic [ModeW-1:0] ModeUndefFirst = 3'd5;
  localparam logic [ModeW-1:0] ModeUndefLast  = 3'd7;

  typedef enum logic [1:0] {
    LOAD_RINGS,
    DRAIN_RINGS,
    MIXED_TRAFFIC
  } traffic_e;

  logic clk;
  logic rst_n;
  bit   idle_on = 1'b1;
  int   failures, results_due, checked;
  int   mode_count [8];
  int   width_writes = 0;
  logic any_accept;

  rs485uf_in_if  req_if ();
  rs485uf_out_if rsp_if ();
  rs485uf_cfg_if cfg_if ();

  rs485_buffered_uart_front dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  rs485uf_result_checker u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .cfg_i         (cfg_if),
    .failures_o    (failures),
    .results_due_o (results_due),
    .checked_o     (checked)
  );

  assign any_accept = (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
                      (cfg_if.valid && cfg_if.ready);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Result side: random stall bursts while idling is on, long ready runs between.
  initial begin
    rsp_if.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (idle_on && $urandom_range(0, 2) == 0) begin
        rsp_if.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk);
      if (!rst_n || any_accept) quiet = 0;
      else quiet++;
    end
    $display("%0t: no handshake for %0d cycles", $time, QuietLimit);
    $display("CHECK FAILED");
    $finish;
  end

  // Leaves valid high after the handshake so that back-to-back requests are possible.
  task automatic send_event(input logic [ModeW-1:0] m, input logic [ByteW-1:0] b);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req_if.valid     <= 1'b1;
    req_if.mode      <= m;
    req_if.data_byte <= b;
    do @(posedge clk); while (!req_if.ready);
    mode_count[m]++;
  endtask

  task automatic wait_results();
    req_if.valid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic write_data_bits(input logic [CfgW-1:0] v);
    cfg_if.valid     <= 1'b1;
    cfg_if.data_bits <= v;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    width_writes++;
  endtask

  function automatic logic [ModeW-1:0] pick_mode(traffic_e t);
    int r;
    int w_rx, w_wr, w_rd, w_rdy, w_done;
    r = $urandom_range(0, 99);
    case (t)
      LOAD_RINGS: begin
        w_rx = 48; w_wr = 46; w_rd = 2; w_rdy = 2; w_done = 1;
      end
      DRAIN_RINGS: begin
        w_rx = 3; w_wr = 3; w_rd = 45; w_rdy = 40; w_done = 8;
      end
      default: begin
        w_rx = 25; w_wr = 20; w_rd = 20; w_rdy = 20; w_done = 10;
      end
    endcase
    if (r < w_rx) return MODE_RX_BYTE;
    r -= w_rx;
    if (r < w_wr) return MODE_HOST_WRITE;
    r -= w_wr;
    if (r < w_rd) return MODE_HOST_READ;
    r -= w_rd;
    if (r < w_rdy) return MODE_TX_READY;
    r -= w_rdy;
    if (r < w_done) return MODE_TX_DONE;
    return ModeW'($urandom_range(ModeUndefFirst, ModeUndefLast));
  endfunction

  // A complete transmit session: writes, one ready per byte plus the one that
  // finds the ring empty, then transmit complete.
  task automatic tx_session(input int n);
    for (int i = 0; i < n; i++) send_event(MODE_HOST_WRITE, ByteW'($urandom_range(0, 255)));
    for (int i = 0; i <= n; i++) send_event(MODE_TX_READY, ByteW'($urandom_range(0, 255)));
    send_event(MODE_TX_DONE, ByteW'($urandom_range(0, 255)));
  endtask

  task automatic run_phase(input traffic_e t, input logic [CfgW-1:0] width, input int n);
    int sent;
    int k;
    wait_results();
    write_data_bits(width);
    sent = 0;
    while (sent < n) begin
      if (t == MIXED_TRAFFIC && $urandom_range(0, 7) == 0) begin
        k = $urandom_range(1, 8);
        tx_session(k);
        sent += 2 * k + 2;
      end else begin
        send_event(pick_mode(t), ByteW'($urandom_range(0, 255)));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    int undef_count;
    rst_n            <= 1'b0;
    req_if.valid     <= 1'b0;
    req_if.mode      <= MODE_RX_BYTE;
    req_if.data_byte <= '0;
    cfg_if.valid     <= 1'b0;
    cfg_if.data_bits <= DataBitsReset;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_data_bits(4'd8);
    // Empty-ring read, a transmitter-ready that nobody asked for, and a
    // transmit complete before the ring drained.
    send_event(MODE_HOST_READ, 8'h00);
    send_event(MODE_TX_READY, 8'h00);
    send_event(MODE_TX_DONE, 8'h00);
    for (int m = ModeUndefFirst; m <= ModeUndefLast; m++) send_event(ModeW'(m), 8'hFF);
    send_event(MODE_RX_BYTE, 8'hFF);
    send_event(MODE_RX_BYTE, 8'h00);
    send_event(MODE_RX_BYTE, 8'hA5);
    repeat (4) send_event(MODE_HOST_READ, 8'h00);
    send_event(MODE_HOST_WRITE, 8'h00);
    send_event(MODE_HOST_WRITE, 8'hFF);
    repeat (3) send_event(MODE_TX_READY, 8'h00);
    send_event(MODE_TX_DONE, 8'h00);
    wait_results();
    write_data_bits(4'd5);
    send_event(MODE_RX_BYTE, 8'hFF);
    send_event(MODE_HOST_READ, 8'h00);

    run_phase(LOAD_RINGS, 4'd8, 150);
    run_phase(DRAIN_RINGS, 4'd6, 150);
    run_phase(MIXED_TRAFFIC, 4'd0, 60);
    run_phase(LOAD_RINGS, 4'd15, 70);
    run_phase(MIXED_TRAFFIC, CfgW'($urandom_range(0, 15)), 50);
    wait_results();
    idle_on = 1'b0;
    run_phase(MIXED_TRAFFIC, 4'd7, 40);

    wait_results();
    repeat (DrainCycles) @(posedge clk);

    undef_count = mode_count[5] + mode_count[6] + mode_count[7];
    $display("Events sent: %0d receive, %0d read, %0d write, %0d tx ready, %0d tx done, %0d undefined",
             mode_count[MODE_RX_BYTE], mode_count[MODE_HOST_READ], mode_count[MODE_HOST_WRITE],
             mode_count[MODE_TX_READY], mode_count[MODE_TX_DONE], undef_count);
    $display("%0d results compared over %0d character width settings", checked, width_writes);
    if (failures == 0 && results_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
